// ----- design/sapf_pkg.sv -----
// ----------------------------------------------------------------------------
// sapf_pkg - shared types and constants of the serial ADC pressure front end
// Item, status and result payloads, configuration register file and indexes.
// ----------------------------------------------------------------------------
package sapf_pkg;

  localparam int CAL_SAMPLES_DEF = 11;
  localparam int ADC_BITS_DEF    = 24;

  localparam int RAW_W      = 24;
  localparam int PRES_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int TIMER_W    = 20;
  localparam int HALF_W     = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FRAC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MANUAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd6;

  typedef struct packed {
    logic data_level;
    logic start_read;
  } item_t;

  typedef struct packed {
    logic                    clock_level;
    logic                    busy_res;
    logic                    sample_done;
    logic                    timed_out;
    logic signed [RAW_W-1:0] raw_value;
    logic                    calibrated;
  } status_t;

  typedef struct packed {
    logic                     clock_level;
    logic                     busy_res;
    logic                     sample_done;
    logic                     timed_out;
    logic signed [RAW_W-1:0]  raw_value;
    logic                     calibrated;
    logic signed [PRES_W-1:0] pressure;
  } result_t;

  typedef struct packed {
    logic        [31:0]        scale_frac;
    logic signed [PRES_W-1:0]  offset_manual;
    logic                      offset_mode;
    logic signed [PRES_W-1:0]  min_limit;
    logic signed [PRES_W-1:0]  max_limit;
    logic        [HALF_W-1:0]  half_bit_ticks;
    logic        [TIMER_W-1:0] timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_frac:     32'd20480,
    offset_manual:  32'sd0,
    offset_mode:    1'b0,
    min_limit:      -32'sd2621440,
    max_limit:      32'sd2621440,
    half_bit_ticks: 8'd5,
    timeout_ticks:  20'd200000
  };

endpackage

// ----- design/sapf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sapf_ctrl - serial read sequencer and calibration store
// Drives the serial clock, shifts in the sample and keeps a sorted store of
// the first reads so that the median of a full store is at a fixed slot.
// ----------------------------------------------------------------------------
module sapf_ctrl #(
  parameter int ADC_BITS    = sapf_pkg::ADC_BITS_DEF,
  parameter int CAL_SAMPLES = sapf_pkg::CAL_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  sapf_pkg::item_t            item,
  input  sapf_pkg::cfg_t             cfg,
  output sapf_pkg::status_t          status,
  output logic signed [ADC_BITS-1:0] cached_next,
  output logic signed [ADC_BITS-1:0] median,
  output logic                       cal_final
);

  localparam int TW   = sapf_pkg::TIMER_W;
  localparam int TW1  = TW + 1;
  localparam int RW   = sapf_pkg::RAW_W;
  localparam int BC_W = $clog2(ADC_BITS + 1);
  localparam int CN_W = $clog2(CAL_SAMPLES + 1);
  localparam int MID  = CAL_SAMPLES / 2;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WAIT  = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_XHIGH = 3'd4;

  logic [2:0]                 phase, phase_next;
  logic [BC_W-1:0]            bit_count, bit_count_next;
  logic [TW-1:0]              tick_timer, tick_timer_next, timer_inc;
  logic [ADC_BITS-1:0]        shift_word, shift_word_next;
  logic signed [ADC_BITS-1:0] last_valid, last_valid_next;
  logic signed [ADC_BITS-1:0] cached_raw;
  logic                       sclk, sclk_next;
  logic [CN_W-1:0]            cal_count, cal_count_next;
  logic signed [ADC_BITS-1:0] cal_sorted [CAL_SAMPLES];
  logic signed [ADC_BITS-1:0] sorted_next [CAL_SAMPLES];
  logic signed [ADC_BITS-1:0] sorted_prev [CAL_SAMPLES];
  logic [CAL_SAMPLES-1:0]     above, above_prev;

  logic                       half_over, done, tmo, push;
  logic signed [ADC_BITS-1:0] push_val;

  assign timer_inc = tick_timer + TW'(1);
  assign half_over = ({1'b0, tick_timer} + TW1'(1)) >= TW1'(cfg.half_bit_ticks);

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_timer_next = tick_timer;
    shift_word_next = shift_word;
    last_valid_next = last_valid;
    cached_next     = cached_raw;
    sclk_next       = sclk;
    done            = 1'b0;
    tmo             = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.start_read) begin
          phase_next      = PH_WAIT;
          tick_timer_next = '0;
        end
      end
      PH_WAIT: begin
        if (!item.data_level) begin
          phase_next      = PH_HIGH;
          sclk_next       = 1'b1;
          tick_timer_next = '0;
          bit_count_next  = '0;
          shift_word_next = '0;
        end else if (tick_timer >= cfg.timeout_ticks) begin
          phase_next      = PH_IDLE;
          tmo             = 1'b1;
          tick_timer_next = '0;
        end else begin
          tick_timer_next = timer_inc;
        end
      end
      PH_HIGH: begin
        if (half_over) begin
          // sample on the falling edge
          shift_word_next = {shift_word[ADC_BITS-2:0], item.data_level};
          bit_count_next  = bit_count + BC_W'(1);
          sclk_next       = 1'b0;
          phase_next      = PH_LOW;
          tick_timer_next = '0;
        end else begin
          tick_timer_next = timer_inc;
        end
      end
      PH_LOW: begin
        if (half_over) begin
          sclk_next       = 1'b1;
          tick_timer_next = '0;
          phase_next      = (bit_count < BC_W'(ADC_BITS)) ? PH_HIGH : PH_XHIGH;
        end else begin
          tick_timer_next = timer_inc;
        end
      end
      default: begin
        // extra pulse high; end of read on its fall
        if (half_over) begin
          sclk_next       = 1'b0;
          phase_next      = PH_IDLE;
          tick_timer_next = '0;
          done            = 1'b1;
          last_valid_next = $signed(shift_word);
          cached_next     = $signed(shift_word);
        end else begin
          tick_timer_next = timer_inc;
        end
      end
    endcase
  end

  // Sorted insertion: entries above the new value move up one slot
  assign push_val       = tmo ? last_valid : $signed(shift_word);
  assign push           = (done || tmo) && (cal_count < CN_W'(CAL_SAMPLES));
  assign cal_count_next = cal_count + CN_W'(push);

  always_comb begin
    above_prev     = '0;
    sorted_prev[0] = push_val;
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      above[i] = (CN_W'(i) < cal_count) && (cal_sorted[i] > push_val);
    end
    for (int i = 1; i < CAL_SAMPLES; i++) begin
      above_prev[i]  = above[i-1];
      sorted_prev[i] = cal_sorted[i-1];
    end
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      if (above_prev[i]) begin
        sorted_next[i] = sorted_prev[i];
      end else if (above[i] || (CN_W'(i) == cal_count)) begin
        sorted_next[i] = push_val;
      end else begin
        sorted_next[i] = cal_sorted[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      tick_timer <= '0;
      shift_word <= '0;
      last_valid <= '0;
      cached_raw <= '0;
      sclk       <= 1'b0;
      cal_count  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tick_timer <= tick_timer_next;
      shift_word <= shift_word_next;
      last_valid <= last_valid_next;
      cached_raw <= cached_next;
      sclk       <= sclk_next;
      cal_count  <= cal_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && push) begin
      cal_sorted <= sorted_next;
    end
  end

  assign median    = sorted_next[MID];
  assign cal_final = push && (cal_count_next == CN_W'(CAL_SAMPLES));

  assign status.clock_level = sclk_next;
  assign status.busy_res    = (phase_next != PH_IDLE);
  assign status.sample_done = done;
  assign status.timed_out   = tmo;
  assign status.raw_value   = RW'(last_valid_next);
  assign status.calibrated  = (cal_count_next >= CN_W'(CAL_SAMPLES));

endmodule

// ----- design/sapf_scale.sv -----
// ----------------------------------------------------------------------------
// sapf_scale - raw count times scale factor
// Signed sample times unsigned 2^-32 scale, full-width product.
// ----------------------------------------------------------------------------
module sapf_scale #(
  parameter int ADC_BITS = sapf_pkg::ADC_BITS_DEF
) (
  input  logic signed [ADC_BITS-1:0] raw,
  input  logic        [31:0]         scale,
  output logic signed [ADC_BITS+32:0] product
);

  localparam int PROD_W = ADC_BITS + 33;

  assign product = PROD_W'(raw) * PROD_W'($signed({1'b0, scale}));

endmodule

// ----- design/sapf_sat.sv -----
// ----------------------------------------------------------------------------
// sapf_sat - signed saturation to 32 bits
// Clip a signed value of any width to the 32-bit two's complement range.
// ----------------------------------------------------------------------------
module sapf_sat #(
  parameter int W = 33
) (
  input  logic signed [W-1:0]                value,
  output logic signed [sapf_pkg::PRES_W-1:0] sat
);

  localparam int PW = sapf_pkg::PRES_W;
  localparam int EW = (W > PW) ? W : PW;
  localparam logic signed [PW-1:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [PW-1:0] MIN32 = 32'sh8000_0000;

  logic signed [EW-1:0] ext;

  assign ext = EW'(value);

  always_comb begin
    if (ext > EW'(MAX32)) begin
      sat = MAX32;
    end else if (ext < EW'(MIN32)) begin
      sat = MIN32;
    end else begin
      sat = PW'(ext);
    end
  end

endmodule

// ----- design/serial_adc_pressure_frontend.sv -----
// ----------------------------------------------------------------------------
// serial_adc_pressure_frontend - serial bridge ADC reader with zero calibration
// One transaction per serial timing tick; reads a 24-bit converter, keeps a
// median zero offset and reports clamped Q16.16 pressure every tick.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                    Payload
// item     in   item_valid / item_stall      sapf_pkg::item_t
// result   out  result_valid / result_stall  sapf_pkg::result_t
// config   in   write_enable                 reg_index, write_data
//
// Rate: one item per cycle while the result channel is not stalled; each item
//   passes through the stage chain behind the sequencer: multiply,
//   round/offset, add, saturate/clamp into the result register.
// Reset: synchronous; clears sequencer, pipeline valids and zero offset and
//   loads register defaults. The calibration store needs no clearing pass.
// Stalls: each stage holds while the one after it is full and stalled;
//   bubbles drain, so items are still taken while a result waits.
// ----------------------------------------------------------------------------
module serial_adc_pressure_frontend #(
  parameter int ADC_BITS    = sapf_pkg::ADC_BITS_DEF,
  parameter int CAL_SAMPLES = sapf_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  sapf_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output sapf_pkg::result_t                   result,
  input  logic                                write_enable,
  input  logic [sapf_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [sapf_pkg::CFG_DATA_W-1:0]     write_data
);

  localparam int PRES_W = sapf_pkg::PRES_W;
  localparam int PROD_W = ADC_BITS + 33;
  localparam int SCL_W  = PROD_W - 16;
  localparam int SUM_W  = ((SCL_W > PRES_W) ? SCL_W : PRES_W) + 1;

  // Register file
  sapf_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sapf_pkg::CFG_RESET;
    end else if (write_enable) begin
      case (reg_index)
        sapf_pkg::REG_SCALE_FRAC:     cfg.scale_frac     <= write_data;
        sapf_pkg::REG_OFFSET_MANUAL:  cfg.offset_manual  <= $signed(write_data);
        sapf_pkg::REG_OFFSET_MODE:    cfg.offset_mode    <= write_data[0];
        sapf_pkg::REG_MIN_LIMIT:      cfg.min_limit      <= $signed(write_data);
        sapf_pkg::REG_MAX_LIMIT:      cfg.max_limit      <= $signed(write_data);
        sapf_pkg::REG_HALF_BIT_TICKS: cfg.half_bit_ticks <= write_data[sapf_pkg::HALF_W-1:0];
        sapf_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= write_data[sapf_pkg::TIMER_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its content moves on
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4, ready_out;
  logic accept;

  assign ready_out  = !result_valid || !result_stall;
  assign ready4     = !v4 || ready_out;
  assign ready3     = !v3 || ready4;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign accept     = item_valid && ready1;
  assign item_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1)    v1           <= accept;
      if (ready2)    v2           <= v1;
      if (ready3)    v3           <= v2;
      if (ready4)    v4           <= v3;
      if (ready_out) result_valid <= v4;
    end
  end

  // Sequencer: advance state on each accepted transaction
  sapf_pkg::status_t          st0;
  logic signed [ADC_BITS-1:0] cached0, median0;
  logic                       final0;

  sapf_ctrl #(
    .ADC_BITS    (ADC_BITS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .item        (item),
    .cfg         (cfg),
    .status      (st0),
    .cached_next (cached0),
    .median      (median0),
    .cal_final   (final0)
  );

  // Stage 1: sequencer outputs
  sapf_pkg::status_t          st1;
  logic signed [ADC_BITS-1:0] cached1, median1;
  logic                       final1;

  // Stage 2: products for the cached sample and for the median
  sapf_pkg::status_t          st2;
  logic signed [PROD_W-1:0]   prod_raw, prod_med, prod2_raw, prod2_med;
  logic                       final2;

  sapf_scale #(.ADC_BITS(ADC_BITS)) u_scale_raw (
    .raw     (cached1),
    .scale   (cfg.scale_frac),
    .product (prod_raw)
  );

  sapf_scale #(.ADC_BITS(ADC_BITS)) u_scale_med (
    .raw     (median1),
    .scale   (cfg.scale_frac),
    .product (prod_med)
  );

  // Round half up to Q16.16; the negated median rounds as (~p + half) >> 16
  logic signed [PROD_W-1:0]  rnd_raw, rnd_neg_med;
  logic signed [SCL_W-1:0]   scaled_raw, neg_scaled_med;
  logic signed [PRES_W-1:0]  zo_cand, zero_offset;

  assign rnd_raw        = prod2_raw + PROD_W'(32768);
  assign rnd_neg_med    = (~prod2_med) + PROD_W'(32768);
  assign scaled_raw     = $signed(rnd_raw[PROD_W-1:16]);
  assign neg_scaled_med = $signed(rnd_neg_med[PROD_W-1:16]);

  sapf_sat #(.W(SCL_W)) u_sat_zero (
    .value (neg_scaled_med),
    .sat   (zo_cand)
  );

  // Latch the zero offset as the calibrating transaction enters stage 3, so
  // it and every later transaction see the new value in stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
    end else if (ready3 && v2 && final2) begin
      zero_offset <= zo_cand;
    end
  end

  // Stage 3: scaled sample
  sapf_pkg::status_t        st3;
  logic signed [SCL_W-1:0]  scaled3;

  // Stage 4: sample plus selected offset
  sapf_pkg::status_t        st4;
  logic signed [PRES_W-1:0] offset_sel;
  logic signed [SUM_W-1:0]  sum, sum4;

  assign offset_sel = cfg.offset_mode ? cfg.offset_manual : zero_offset;
  assign sum        = SUM_W'(scaled3) + SUM_W'(offset_sel);

  // Output: saturate, then clamp with the lower limit checked first
  logic signed [PRES_W-1:0] p_sat, p_clamp;

  sapf_sat #(.W(SUM_W)) u_sat_pres (
    .value (sum4),
    .sat   (p_sat)
  );

  always_comb begin
    if (p_sat < cfg.min_limit) begin
      p_clamp = cfg.min_limit;
    end else if (p_sat > cfg.max_limit) begin
      p_clamp = cfg.max_limit;
    end else begin
      p_clamp = p_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      st1     <= st0;
      cached1 <= cached0;
      median1 <= median0;
      final1  <= final0;
    end
    if (ready2) begin
      st2       <= st1;
      prod2_raw <= prod_raw;
      prod2_med <= prod_med;
      final2    <= final1;
    end
    if (ready3) begin
      st3     <= st2;
      scaled3 <= scaled_raw;
    end
    if (ready4) begin
      st4  <= st3;
      sum4 <= sum;
    end
    if (ready_out) begin
      result.clock_level <= st4.clock_level;
      result.busy_res    <= st4.busy_res;
      result.sample_done <= st4.sample_done;
      result.timed_out   <= st4.timed_out;
      result.raw_value   <= st4.raw_value;
      result.calibrated  <= st4.calibrated;
      result.pressure    <= p_clamp;
    end
  end

endmodule

// ----- design/sapf_checker.sv -----
// ----------------------------------------------------------------------------
// sapf_checker - port-level checks of the pressure front end
// Watches the result channel for consistent read status over time.
// ----------------------------------------------------------------------------
module sapf_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input sapf_pkg::result_t result
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A read ends either by success or by timeout, never both
  a_one_end: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.sample_done && result.timed_out))
    else $error("done and timeout together");

  // The end of a read leaves the sequencer idle with the clock low
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.sample_done || result.timed_out)
      |-> !result.busy_res && !result.clock_level)
    else $error("read ended while still busy");

  // The serial clock is only driven high inside a read
  a_clk_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clock_level |-> result.busy_res)
    else $error("serial clock high while idle");

endmodule

bind serial_adc_pressure_frontend sapf_checker u_sapf_checker (.*);
